// ----- hdl/s256_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies; the hasher, the checker and the bench refer to it by scoped names.
package s256_pkg;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    // Input function codes
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Block geometry and padding
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sigma functions of the round and the message schedule
    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ----- hdl/s256_if.sv -----
// Valid/ready channel interfaces of the SHA-256 stream hasher.
// Standalone; byte input channel and digest output channel.
interface s256_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface s256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ----- hdl/sha256_stream_hasher.sv -----
// Absorb word: the 64th byte of a block starts the rounds, then the add step.
// Finish word: padding to the end of the block, rounds and add, twice when fill >= 56,
// then 8 digest words, one per cycle while the receiver is ready. One round of the shared
// round unit per cycle sets the block time. Synchronous active-low reset restores the initial
// hash values, clears the byte count and returns the sequencer to idle.
module sha256_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    s256_in_if.sink       i_byte_ch,
    s256_out_if.source    o_dig_ch
);

    s256_pkg::t_state r_state;
    logic [511:0]     r_blk;
    logic [31:0]      r_hash [8];
    logic [31:0]      r_v    [8];
    logic [5:0]       r_round;
    logic [5:0]       r_fill;
    logic [60:0]      r_total;
    logic [63:0]      r_len;
    logic             r_pad_first;
    logic             r_second;
    logic             r_pad;
    logic [2:0]       r_idx;

    logic             in_acc;
    logic             out_acc;
    logic             is_len_byte;
    logic [7:0]       pad_byte;
    logic [31:0]      t1;
    logic [31:0]      t2;
    logic [31:0]      w_new;
    logic [31:0]      w_cur;

    // Handshakes
    assign i_byte_ch.ready = (r_state == s256_pkg::ST_IDLE);
    assign in_acc          = i_byte_ch.valid && i_byte_ch.ready;
    assign o_dig_ch.valid       = (r_state == s256_pkg::ST_EMIT);
    assign o_dig_ch.digest_word = r_hash[r_idx];
    assign o_dig_ch.word_index  = r_idx;
    assign o_dig_ch.last_word   = (r_idx == s256_pkg::WORD_LAST);
    assign out_acc         = o_dig_ch.valid && o_dig_ch.ready;

    // Pick the padding byte: marker, then zeros, then the bit length in the final block
    assign is_len_byte = !r_pad_first && (r_fill >= s256_pkg::LEN_POS) && !r_second;
    always_comb begin
        if (r_pad_first) begin
            pad_byte = s256_pkg::PAD_MARK;
        end else if (is_len_byte) begin
            pad_byte = r_len[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Shared round unit: one compression round and one schedule word per cycle
    assign w_cur = r_blk[511:480];
    assign t1 = r_v[7] + s256_pkg::big_sig1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + s256_pkg::ROUND_K[r_round] + w_cur;
    assign t2 = s256_pkg::big_sig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = w_cur + s256_pkg::small_sig0(r_blk[479:448])
                 + r_blk[223:192] + s256_pkg::small_sig1(r_blk[63:32]);

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= s256_pkg::ST_IDLE;
            r_hash      <= s256_pkg::INIT_HASH;
            r_total     <= '0;
            r_fill      <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_pad       <= 1'b0;
            r_pad_first <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            case (r_state)
                s256_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (i_byte_ch.func == s256_pkg::FUNC_ABSORB) begin
                            r_total <= r_total + 61'd1;
                            r_fill  <= r_fill + 6'd1;
                            if (r_fill == s256_pkg::FILL_LAST) begin
                                r_round <= '0;
                                r_state <= s256_pkg::ST_ROUND;
                            end
                        end else begin
                            r_pad       <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_second    <= (r_fill >= s256_pkg::LEN_POS);
                            r_state     <= s256_pkg::ST_PAD;
                        end
                    end
                end
                s256_pkg::ST_PAD: begin
                    r_pad_first <= 1'b0;
                    r_fill      <= r_fill + 6'd1;
                    if (r_fill == s256_pkg::FILL_LAST) begin
                        r_round <= '0;
                        r_state <= s256_pkg::ST_ROUND;
                    end
                end
                s256_pkg::ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == s256_pkg::ROUND_LAST) begin
                        r_state <= s256_pkg::ST_ADD;
                    end
                end
                s256_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    if (!r_pad) begin
                        r_state <= s256_pkg::ST_IDLE;
                    end else if (r_second) begin
                        r_second <= 1'b0;
                        r_state  <= s256_pkg::ST_PAD;
                    end else begin
                        r_idx   <= '0;
                        r_state <= s256_pkg::ST_EMIT;
                    end
                end
                s256_pkg::ST_EMIT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == s256_pkg::WORD_LAST) begin
                            r_hash  <= s256_pkg::INIT_HASH;
                            r_total <= '0;
                            r_fill  <= '0;
                            r_pad   <= 1'b0;
                            r_state <= s256_pkg::ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= s256_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: block window, working variables, length shifter
    always_ff @(posedge i_clk) begin
        case (r_state)
            s256_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_ch.func == s256_pkg::FUNC_ABSORB) begin
                        r_blk <= {r_blk[503:0], i_byte_ch.data_byte};
                        if (r_fill == s256_pkg::FILL_LAST) begin
                            r_v <= r_hash;
                        end
                    end else begin
                        r_len <= {r_total, 3'b000};
                    end
                end
            end
            s256_pkg::ST_PAD: begin
                r_blk <= {r_blk[503:0], pad_byte};
                if (is_len_byte) begin
                    r_len <= {r_len[55:0], 8'h00};
                end
                if (r_fill == s256_pkg::FILL_LAST) begin
                    r_v <= r_hash;
                end
            end
            s256_pkg::ST_ROUND: begin
                r_blk <= {r_blk[479:0], w_new};
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            default: begin
                // hold
            end
        endcase
    end

endmodule

// ----- hdl/s256_checker.sv -----
// Port-level checker of the SHA-256 stream hasher, bound to its top level.
// Depends on s256_pkg, sha256_stream_hasher and the channel interfaces.
module s256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_func,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_index,
    input logic        i_out_last
);

    // A stalled digest word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_word) && $stable(i_out_index)))
        else $error("digest word changed while stalled");

    // Never take a byte while the digest is going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input ready during digest output");

    // Digest words follow in order without a gap
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && (i_out_index == $past(i_out_index) + 3'd1)))
        else $error("digest word index did not advance");

    // Drop valid after the final word
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("valid stayed high after the final digest word");

    // A finish word makes the block busy at once
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_func == s256_pkg::FUNC_FINISH)) |=> !i_in_ready)
        else $error("ready stayed high after a finish word");

endmodule

bind sha256_stream_hasher s256_checker u_s256_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte_ch.valid),
    .i_in_ready  (i_byte_ch.ready),
    .i_in_func   (i_byte_ch.func),
    .i_out_valid (o_dig_ch.valid),
    .i_out_ready (o_dig_ch.ready),
    .i_out_word  (o_dig_ch.digest_word),
    .i_out_index (o_dig_ch.word_index),
    .i_out_last  (o_dig_ch.last_word)
);

// ----- bench/tb_sha256_stream_hasher.sv -----
// Self-checking bench of sha256_stream_hasher: byte streams in, digest words out.
// Depends on hdl/s256_pkg.sv, hdl/s256_if.sv and the hasher top level.
// A directed table, then boundary and random messages scored by an in-bench SHA-256.
module tb_sha256_stream_hasher;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 400;
    localparam int TAIL_WAIT  = 300;
    localparam int RAND_ITEMS = 340;
    localparam int N_DIR      = 15;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } dig_word_t;

    typedef struct packed {
        logic         func;
        logic [7:0]   data;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    s256_in_if  in_ch ();
    s256_out_if out_ch ();

    sha256_stream_hasher i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte_ch(in_ch),
        .o_dig_ch (out_ch)
    );

    // Hasher state mirrored by the bench
    logic [31:0] chain_h [8];
    logic [7:0]  blk_buf [64];
    logic [60:0] byte_cnt;

    dig_word_t digest_q [$];
    dig_word_t want;
    stim_row_t dir_rows [N_DIR];

    int  err_count   = 0;
    int  items_done  = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  hold_req    = 1'b0;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compress the buffered block into the chaining words
    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        end
        for (i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++) v[i] = chain_h[i];
        for (i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endtask

    // Return to the start of a new message
    task automatic clear_hash_state();
        int i;
        for (i = 0; i < 8; i++) chain_h[i] = H_START[i];
        byte_cnt = '0;
    endtask

    // Store one message byte, compress on a full block
    task automatic absorb_byte(input logic [7:0] b);
        int fill;
        fill = int'(byte_cnt[5:0]);
        blk_buf[fill] = b;
        byte_cnt = byte_cnt + 1'b1;
        if (fill == 63) fold_block();
    endtask

    // Pad, append the bit length, compress and return the digest
    task automatic close_message(output logic [255:0] dig);
        logic [63:0] bits;
        int fill, i;
        fill = int'(byte_cnt[5:0]);
        bits = {byte_cnt, 3'b000};
        blk_buf[fill] = 8'h80;
        for (i = fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
        if (fill >= 56) begin
            fold_block();
            for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;
        end
        for (i = 0; i < 8; i++) blk_buf[56+i] = bits[63-8*i -: 8];
        fold_block();
        for (i = 0; i < 8; i++) dig[255-32*i -: 32] = chain_h[i];
        clear_hash_state();
    endtask

    // Offer one word, hold it until accepted, then update the prediction
    task automatic send_word(input logic f, input logic [7:0] b,
                             input logic known, input logic [255:0] ref_dig);
        logic [255:0] dig;
        dig_word_t dw;
        int gap, i;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_done++;
        if (f == s256_pkg::FUNC_ABSORB) begin
            absorb_byte(b);
        end else begin
            close_message(dig);
            if (known) dig = ref_dig;
            for (i = 0; i < 8; i++) begin
                dw = '{dig[255-32*i -: 32], 3'(i), (i == 7)};
                digest_q.insert(digest_q.size(), dw);
            end
        end
    endtask

    // Send a message of the given length with random or flat content
    task automatic send_message(input int len);
        int i, style;
        logic [7:0] b;
        style = $urandom_range(0, 7);
        for (i = 0; i < len; i++) begin
            case (style)
                0:       b = 8'h00;
                1:       b = 8'hff;
                default: b = 8'($urandom);
            endcase
            send_word(s256_pkg::FUNC_ABSORB, b, 1'b0, '0);
        end
        send_word(s256_pkg::FUNC_FINISH, 8'($urandom), 1'b0, '0);
    endtask

    // Stop offering and wait until every digest word has arrived
    task automatic drain_digests();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input dig_word_t got, input bit have_want,
                                 input dig_word_t w);
        if (err_count < 10) begin
            if (have_want)
                $display("mismatch: expected word %h idx %0d last %b, got %h idx %0d last %b",
                         w.word, w.idx, w.last, got.word, got.idx, got.last);
            else
                $display("mismatch: unexpected word %h idx %0d last %b",
                         got.word, got.idx, got.last);
        end
        err_count++;
    endtask

    // Score each accepted digest word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_q.size() == 0) begin
                note_mismatch('{out_ch.digest_word, out_ch.word_index, out_ch.last_word},
                              1'b0, '0);
            end else begin
                want = digest_q.pop_front();
                if (out_ch.digest_word !== want.word || out_ch.word_index !== want.idx ||
                    out_ch.last_word !== want.last)
                    note_mismatch('{out_ch.digest_word, out_ch.word_index,
                                    out_ch.last_word}, 1'b1, want);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: stall pattern that switches between randomly drawn modes
    initial begin : rx_proc
        int hold_left, phase, mode;
        hold_left = 0;
        phase = 0;
        mode = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (phase % 48 == 0) mode = $urandom_range(0, 3);
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= (phase % 4 != 0);
                    2:       out_ch.ready <= 1'($urandom);
                    default: out_ch.ready <= (phase % 3 == 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin : main_proc
        int i, len, rand_start;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= s256_pkg::FUNC_ABSORB;
        in_ch.data_byte <= 8'h00;
        clear_hash_state();
        for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;

        // empty message right after reset, then again with a junk byte on finish
        dir_rows[0]  = '{s256_pkg::FUNC_FINISH, 8'h00, 1'b1, EMPTY_DIGEST};
        dir_rows[1]  = '{s256_pkg::FUNC_FINISH, 8'hff, 1'b1, EMPTY_DIGEST};
        dir_rows[2]  = '{s256_pkg::FUNC_ABSORB, 8'h61, 1'b0, 256'd0};
        dir_rows[3]  = '{s256_pkg::FUNC_ABSORB, 8'h62, 1'b0, 256'd0};
        dir_rows[4]  = '{s256_pkg::FUNC_ABSORB, 8'h63, 1'b0, 256'd0};
        dir_rows[5]  = '{s256_pkg::FUNC_FINISH, 8'h5a, 1'b1, ABC_DIGEST};
        dir_rows[6]  = '{s256_pkg::FUNC_ABSORB, 8'h00, 1'b0, 256'd0};
        dir_rows[7]  = '{s256_pkg::FUNC_FINISH, 8'h00, 1'b0, 256'd0};
        dir_rows[8]  = '{s256_pkg::FUNC_ABSORB, 8'hff, 1'b0, 256'd0};
        dir_rows[9]  = '{s256_pkg::FUNC_ABSORB, 8'hff, 1'b0, 256'd0};
        dir_rows[10] = '{s256_pkg::FUNC_FINISH, 8'hff, 1'b0, 256'd0};
        dir_rows[11] = '{s256_pkg::FUNC_ABSORB, 8'h80, 1'b0, 256'd0};
        dir_rows[12] = '{s256_pkg::FUNC_ABSORB, 8'h7f, 1'b0, 256'd0};
        dir_rows[13] = '{s256_pkg::FUNC_ABSORB, 8'h01, 1'b0, 256'd0};
        dir_rows[14] = '{s256_pkg::FUNC_FINISH, 8'h00, 1'b0, 256'd0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (i = 0; i < N_DIR; i++) begin
            send_word(dir_rows[i].func, dir_rows[i].data, dir_rows[i].known,
                      dir_rows[i].digest);
        end
        rand_start = items_done;

        // Long output hold while bytes keep coming, so the input backs up
        hold_req = 1'b1;
        send_message(6);
        send_message(3);

        // Padding boundaries: last single block, second padding block, full blocks
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        drain_digests();

        // Random messages, mostly short, some near or past a block
        while (items_done < rand_start + RAND_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(0, 12);
            send_message(len);
        end

        drain_digests();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0 && digest_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
